FILE: src/spring_damper_force_assert.svh
// Assertion macros for the spring damper force block.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SPRING_DAMPER_FORCE_ASSERT_SVH
`define SPRING_DAMPER_FORCE_ASSERT_SVH
`ifndef SYNTHESIS
`define SDF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spring_damper_force: assertion failed");
`define SDF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spring_damper_force: assertion failed");
`else
`define SDF_ASSERT_NOW(lbl, ante, cons)
`define SDF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/sdf_pkg.sv
// Shared types and constants of the spring damper force block.
// No dependencies.
package sdf_pkg;

	localparam int DATA_W    = 32;
	localparam int REST_W    = DATA_W - 1;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	// Products are clamped to +-2^CAP_LOG2 in magnitude.
	localparam int CAP_LOG2  = 61;

	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 1'd1;

	localparam logic [CFG_W-1:0] STIFFNESS_RST = 32'd65536;
	localparam logic [CFG_W-1:0] DAMPING_RST   = 32'd65536;

	typedef struct packed {
		logic signed [DATA_W-1:0] a_pos_x;
		logic signed [DATA_W-1:0] a_pos_y;
		logic signed [DATA_W-1:0] a_pos_z;
		logic signed [DATA_W-1:0] b_pos_x;
		logic signed [DATA_W-1:0] b_pos_y;
		logic signed [DATA_W-1:0] b_pos_z;
		logic signed [DATA_W-1:0] rel_vel_x;
		logic signed [DATA_W-1:0] rel_vel_y;
		logic signed [DATA_W-1:0] rel_vel_z;
		logic [REST_W-1:0]        rest_len;
		logic                     both_fixed;
	} spring_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic signed [DATA_W-1:0] force_z;
		logic                     skipped;
		logic                     zero_length;
	} force_t;

endpackage

FILE: src/sdf_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// No package dependencies.
module sdf_sqrt #(
	parameter int ROOT_W = 33,
	parameter int SB_W   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [2*ROOT_W-1:0]   rad,
	input  logic [SB_W-1:0]       in_sb,
	output logic                  out_vld,
	output logic [ROOT_W-1:0]     root,
	output logic [SB_W-1:0]       out_sb
);

	localparam int RAD_W = 2 * ROOT_W;

	logic              vld_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rem_s  [ROOT_W];
	logic [SB_W-1:0]   sb_s   [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		localparam int B = ROOT_W - 1 - j;
		logic              vld_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rem_in;
		logic [RAD_W-1:0]  inc;
		logic [SB_W-1:0]   sb_in;
		logic              fits;

		if (j == 0) begin : g_head
			assign vld_in  = in_vld;
			assign root_in = '0;
			assign rem_in  = rad;
			assign sb_in   = in_sb;
		end else begin : g_link
			assign vld_in  = vld_s[j-1];
			assign root_in = root_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign sb_in   = sb_s[j-1];
		end

		// (r + 2^B)^2 - r^2 with r holding only bits above B
		assign inc  = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));
		assign fits = rem_in >= inc;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[j] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
				rem_s[j]  <= fits ? (rem_in - inc) : rem_in;
				sb_s[j]   <= sb_in;
			end
		end
	end

	assign out_vld = vld_s[ROOT_W-1];
	assign root    = root_s[ROOT_W-1];
	assign out_sb  = sb_s[ROOT_W-1];

endmodule

FILE: src/sdf_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage; numerators must not exceed the divisor. No package use.
module sdf_div #(
	parameter int DEN_W = 33,
	parameter int Q_W   = 17,
	parameter int SB_W  = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [DEN_W-1:0]       den,
	input  logic [2:0][DEN_W-1:0]  num,
	input  logic [SB_W-1:0]        in_sb,
	output logic                   out_vld,
	output logic [2:0][Q_W-1:0]    quo,
	output logic [DEN_W-1:0]       out_den,
	output logic [SB_W-1:0]        out_sb
);

	logic                  vld_s [Q_W];
	logic [DEN_W-1:0]      den_s [Q_W];
	logic [2:0][DEN_W:0]   rem_s [Q_W];
	logic [2:0][Q_W-1:0]   quo_s [Q_W];
	logic [SB_W-1:0]       sb_s  [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		localparam int B = Q_W - 1 - j;
		logic                vld_in;
		logic [DEN_W-1:0]    den_in;
		logic [2:0][DEN_W:0] rem_in;
		logic [2:0][Q_W-1:0] quo_in;
		logic [SB_W-1:0]     sb_in;
		logic [2:0][DEN_W:0] rem_nx;
		logic [2:0][Q_W-1:0] quo_nx;

		if (j == 0) begin : g_head
			assign vld_in = in_vld;
			assign den_in = den;
			assign quo_in = '0;
			assign sb_in  = in_sb;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = {1'b0, num[i]};
			end
		end else begin : g_link
			assign vld_in = vld_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
			assign sb_in  = sb_s[j-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = {rem_s[j-1][i][DEN_W-1:0], 1'b0};
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if (rem_in[i] >= {1'b0, den_in}) begin
					rem_nx[i] = rem_in[i] - {1'b0, den_in};
					quo_nx[i] = quo_in[i] | (Q_W'(1) << B);
				end else begin
					rem_nx[i] = rem_in[i];
					quo_nx[i] = quo_in[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_in;
				rem_s[j] <= rem_nx;
				quo_s[j] <= quo_nx;
				sb_s[j]  <= sb_in;
			end
		end
	end

	assign out_vld = vld_s[Q_W-1];
	assign quo     = quo_s[Q_W-1];
	assign out_den = den_s[Q_W-1];
	assign out_sb  = sb_s[Q_W-1];

endmodule

FILE: src/spring_damper_force.sv
// Stages from request accept to result valid, Q16.16 at the default FRAC_BITS:
// 3 input stages, DATA_W+1 root stages, FRAC_BITS+1 divide stages, 7 force
// stages. Throughput: one request per cycle; the whole pipeline advances together
// whenever the output register is empty or taken.
// Reset: arst_n clears all valid bits and loads stiffness and damping with 1.0.
// Depends on sdf_pkg, sdf_sqrt, sdf_div and spring_damper_force_assert.svh.
`include "spring_damper_force_assert.svh"

module spring_damper_force #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            spring_valid,
	output logic                            spring_ready,
	input  sdf_pkg::spring_t                spring,
	output logic                            result_valid,
	input  logic                            result_ready,
	output sdf_pkg::force_t                 result,
	input  logic                            cfg_we,
	input  logic [sdf_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sdf_pkg::CFG_W-1:0]       cfg_data
);

	localparam int W      = sdf_pkg::DATA_W;
	localparam int F      = FRAC_BITS;
	localparam int LW     = W + 1;          // distance magnitude and root width
	localparam int EW     = F + 1;          // unit component magnitude, <= 1.0
	localparam int PV_W   = W + EW;         // |v| * |e|
	localparam int VR_W   = W + 2;          // signed vr and signed l - rest
	localparam int VRM_W  = W + 1;
	localparam int PK_W   = sdf_pkg::CFG_W + VRM_W;
	localparam int FM_W   = sdf_pkg::CAP_LOG2 + 2;
	localparam int FS_W   = sdf_pkg::CAP_LOG2 + 3;
	localparam int CMP_W  = (PK_W > FM_W) ? PK_W : FM_W;
	localparam int LO_W   = (FM_W + 1) / 2;
	localparam int HI_W   = FM_W - LO_W;
	localparam int PP_W   = FM_W + EW;
	localparam int REST_W = sdf_pkg::REST_W;

	localparam logic [CMP_W-1:0] CAP      = CMP_W'(1) << sdf_pkg::CAP_LOG2;
	localparam logic [PP_W-1:0]  POS_LIM  = (PP_W'(1) << (W - 1)) - PP_W'(1);
	localparam logic [PP_W-1:0]  NEG_LIM  = PP_W'(1) << (W - 1);
	localparam logic [W-1:0]     OUT_MAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]     OUT_MIN  = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [2:0]         dneg;
		logic [2:0][LW-1:0] dmag;
		logic [2:0]         vneg;
		logic [2:0][W-1:0]  vmag;
		logic [REST_W-1:0]  rest;
		logic               fixed;
	} side_t;

	typedef struct packed {
		logic [2:0]         dneg;
		logic [2:0]         vneg;
		logic [2:0][W-1:0]  vmag;
		logic [REST_W-1:0]  rest;
		logic               fixed;
	} side2_t;

	// Configuration registers; the user must write them only while the pipe is idle (not enforced here).
	logic [sdf_pkg::CFG_W-1:0] stiffness_q;
	logic [sdf_pkg::CFG_W-1:0] damping_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= sdf_pkg::STIFFNESS_RST;
			damping_q   <= sdf_pkg::DAMPING_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sdf_pkg::REG_STIFFNESS: stiffness_q <= cfg_data;
				sdf_pkg::REG_DAMPING:   damping_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// One enable for the whole pipe: advance when the output slot frees up.
	logic en;
	logic vld_s10;

	assign en           = !vld_s10 || result_ready;
	assign spring_ready = en;

	// ---------------------------------------------------------------------
	// Stage 1: d = b - a, split signs and magnitudes of d and v.
	// ---------------------------------------------------------------------
	logic signed [W-1:0] a_pos [3];
	logic signed [W-1:0] b_pos [3];
	logic signed [W-1:0] vel   [3];
	side_t               side_in;

	assign a_pos[0] = spring.a_pos_x;
	assign a_pos[1] = spring.a_pos_y;
	assign a_pos[2] = spring.a_pos_z;
	assign b_pos[0] = spring.b_pos_x;
	assign b_pos[1] = spring.b_pos_y;
	assign b_pos[2] = spring.b_pos_z;
	assign vel[0]   = spring.rel_vel_x;
	assign vel[1]   = spring.rel_vel_y;
	assign vel[2]   = spring.rel_vel_z;

	always_comb begin
		logic signed [W:0] diff;
		side_in = '0;
		for (int i = 0; i < 3; i++) begin
			diff              = {b_pos[i][W-1], b_pos[i]} - {a_pos[i][W-1], a_pos[i]};
			side_in.dneg[i]   = diff[W];
			// the most negative value negates onto its own pattern, which is
			// the right magnitude read as unsigned
			side_in.dmag[i]   = diff[W] ? LW'(-diff) : LW'(diff);
			side_in.vneg[i]   = vel[i][W-1];
			side_in.vmag[i]   = vel[i][W-1] ? W'(-vel[i]) : W'(vel[i]);
		end
		side_in.rest  = spring.rest_len;
		side_in.fixed = spring.both_fixed;
	end

	logic  vld_s1;
	side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= spring_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) side_s1 <= side_in;
	end

	// ---------------------------------------------------------------------
	// Stage 2: square each component magnitude.
	// ---------------------------------------------------------------------
	logic                 vld_s2;
	side_t                side_s2;
	logic [2:0][2*LW-1:0] sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= side_s1.dmag[i] * side_s1.dmag[i];
			end
			side_s2 <= side_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: sum of squares, held exactly (below 2^(2*LW)).
	// ---------------------------------------------------------------------
	logic            vld_s3;
	side_t           side_s3;
	logic [2*LW-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3 <= side_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Distance: floor square root over LW stages.
	// ---------------------------------------------------------------------
	logic                 sq_vld;
	logic [LW-1:0]        dist_sq;
	logic [$bits(side_t)-1:0] side_sq_raw;
	side_t                side_sq;
	side2_t               side2_sq;

	sdf_sqrt #(
		.ROOT_W (LW),
		.SB_W   ($bits(side_t))
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.rad     (rad_s3),
		.in_sb   (side_s3),
		.out_vld (sq_vld),
		.root    (dist_sq),
		.out_sb  (side_sq_raw)
	);

	assign side_sq        = side_t'(side_sq_raw);
	assign side2_sq.dneg  = side_sq.dneg;
	assign side2_sq.vneg  = side_sq.vneg;
	assign side2_sq.vmag  = side_sq.vmag;
	assign side2_sq.rest  = side_sq.rest;
	assign side2_sq.fixed = side_sq.fixed;

	// ---------------------------------------------------------------------
	// Unit direction: |d_i| * 2^F / l over EW stages, three lanes.
	// ---------------------------------------------------------------------
	logic                      dv_vld;
	logic [2:0][EW-1:0]        quo_dv;
	logic [LW-1:0]             dist_dv;
	logic [$bits(side2_t)-1:0] side2_dv_raw;
	side2_t                    side2_dv;

	sdf_div #(
		.DEN_W (LW),
		.Q_W   (EW),
		.SB_W  ($bits(side2_t))
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.den     (dist_sq),
		.num     (side_sq.dmag),
		.in_sb   (side2_sq),
		.out_vld (dv_vld),
		.quo     (quo_dv),
		.out_den (dist_dv),
		.out_sb  (side2_dv_raw)
	);

	assign side2_dv = side2_t'(side2_dv_raw);

	// ---------------------------------------------------------------------
	// Stage 4: relative velocity times direction, per lane, on magnitudes.
	// ---------------------------------------------------------------------
	logic                vld_s4;
	logic [2:0][PV_W-1:0] pvm_s4;
	logic [2:0]          pvn_s4;
	logic [2:0][EW-1:0]  quo_s4;
	logic [2:0]          eneg_s4;
	logic [LW-1:0]       dist_s4;
	logic [REST_W-1:0]   rest_s4;
	logic                fixed_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pvm_s4[i] <= side2_dv.vmag[i] * quo_dv[i];
			end
			// a zero magnitude makes the sign harmless
			pvn_s4   <= side2_dv.vneg ^ side2_dv.dneg;
			quo_s4   <= quo_dv;
			eneg_s4  <= side2_dv.dneg;
			dist_s4  <= dist_dv;
			rest_s4  <= side2_dv.rest;
			fixed_s4 <= side2_dv.fixed;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: vr = sum of truncated products; stretch x = l - rest.
	// ---------------------------------------------------------------------
	logic [VRM_W-1:0]    vrmag_nx;
	logic                vrneg_nx;
	logic [VRM_W-1:0]    xmag_nx;
	logic                xneg_nx;

	always_comb begin
		logic signed [VR_W-1:0] term;
		logic signed [VR_W-1:0] vr;
		logic signed [VR_W-1:0] x;
		vr = '0;
		for (int i = 0; i < 3; i++) begin
			term = VR_W'(pvm_s4[i] >> F);
			vr   = pvn_s4[i] ? (vr - term) : (vr + term);
		end
		vrneg_nx = vr[VR_W-1];
		vrmag_nx = vrneg_nx ? VRM_W'(-vr) : VRM_W'(vr);
		x        = VR_W'(dist_s4) - VR_W'(rest_s4);
		xneg_nx  = x[VR_W-1];
		xmag_nx  = xneg_nx ? VRM_W'(-x) : VRM_W'(x);
	end

	logic                vld_s5;
	logic [VRM_W-1:0]    vrmag_s5;
	logic                vrneg_s5;
	logic [VRM_W-1:0]    xmag_s5;
	logic                xneg_s5;
	logic [2:0][EW-1:0]  quo_s5;
	logic [2:0]          eneg_s5;
	logic                zero_s5;
	logic                fixed_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vrmag_s5 <= vrmag_nx;
			vrneg_s5 <= vrneg_nx;
			xmag_s5  <= xmag_nx;
			xneg_s5  <= xneg_nx;
			quo_s5   <= quo_s4;
			eneg_s5  <= eneg_s4;
			// the root is zero exactly when the distance is zero
			zero_s5  <= (dist_s4 == '0);
			fixed_s5 <= fixed_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 6: stiffness * x and damping * vr, raw magnitudes.
	// ---------------------------------------------------------------------
	logic                vld_s6;
	logic [PK_W-1:0]     pk_s6;
	logic [PK_W-1:0]     pd_s6;
	logic                xneg_s6;
	logic                vrneg_s6;
	logic [2:0][EW-1:0]  quo_s6;
	logic [2:0]          eneg_s6;
	logic                zero_s6;
	logic                fixed_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pk_s6    <= stiffness_q * xmag_s5;
			pd_s6    <= damping_q * vrmag_s5;
			xneg_s6  <= xneg_s5;
			vrneg_s6 <= vrneg_s5;
			quo_s6   <= quo_s5;
			eneg_s6  <= eneg_s5;
			zero_s6  <= zero_s5;
			fixed_s6 <= fixed_s5;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 7: scale down, clamp to the product cap, apply signs.
	// ---------------------------------------------------------------------
	logic signed [FS_W-1:0] ka_nx;
	logic signed [FS_W-1:0] kb_nx;

	always_comb begin
		logic [CMP_W-1:0] ma;
		logic [CMP_W-1:0] mb;
		ma    = CMP_W'(pk_s6 >> F);
		mb    = CMP_W'(pd_s6 >> F);
		ma    = (ma > CAP) ? CAP : ma;
		mb    = (mb > CAP) ? CAP : mb;
		ka_nx = xneg_s6  ? -FS_W'(ma) : FS_W'(ma);
		kb_nx = vrneg_s6 ? -FS_W'(mb) : FS_W'(mb);
	end

	logic                   vld_s7;
	logic signed [FS_W-1:0] ka_s7;
	logic signed [FS_W-1:0] kb_s7;
	logic [2:0][EW-1:0]     quo_s7;
	logic [2:0]             eneg_s7;
	logic                   zero_s7;
	logic                   fixed_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ka_s7    <= ka_nx;
			kb_s7    <= kb_nx;
			quo_s7   <= quo_s6;
			eneg_s7  <= eneg_s6;
			zero_s7  <= zero_s6;
			fixed_s7 <= fixed_s6;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 8: force scalar fsd = k(l - rest) - c vr, as sign and magnitude.
	// ---------------------------------------------------------------------
	logic [FM_W-1:0] fmag_nx;
	logic            fneg_nx;

	always_comb begin
		logic signed [FS_W-1:0] fsd;
		fsd     = ka_s7 - kb_s7;
		fneg_nx = fsd[FS_W-1];
		fmag_nx = fneg_nx ? FM_W'(-fsd) : FM_W'(fsd);
	end

	logic                vld_s8;
	logic [FM_W-1:0]     fmag_s8;
	logic                fneg_s8;
	logic [2:0][EW-1:0]  quo_s8;
	logic [2:0]          eneg_s8;
	logic                zero_s8;
	logic                fixed_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmag_s8  <= fmag_nx;
			fneg_s8  <= fneg_nx;
			quo_s8   <= quo_s7;
			eneg_s8  <= eneg_s7;
			zero_s8  <= zero_s7;
			fixed_s8 <= fixed_s7;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 9: fsd * e_i as two partial products per lane.
	// ---------------------------------------------------------------------
	logic                      vld_s9;
	logic [2:0][LO_W+EW-1:0]   pl_s9;
	logic [2:0][HI_W+EW-1:0]   ph_s9;
	logic [2:0]                fn_s9;
	logic                      zero_s9;
	logic                      fixed_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s9[i] <= fmag_s8[LO_W-1:0] * quo_s8[i];
				ph_s9[i] <= fmag_s8[FM_W-1:LO_W] * quo_s8[i];
			end
			fn_s9    <= {3{fneg_s8}} ^ eneg_s8;
			zero_s9  <= zero_s8;
			fixed_s9 <= fixed_s8;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 10: join partials, scale down, saturate; output register.
	// Both fixed wins over zero distance; either forces zero.
	// ---------------------------------------------------------------------
	logic [2:0][W-1:0] frc_nx;

	always_comb begin
		logic [PP_W-1:0] prod;
		logic [PP_W-1:0] m;
		for (int i = 0; i < 3; i++) begin
			prod = (PP_W'(ph_s9[i]) << LO_W) + PP_W'(pl_s9[i]);
			m    = prod >> F;
			if (fn_s9[i]) begin
				frc_nx[i] = (m > NEG_LIM) ? OUT_MIN : W'(-m);
			end else begin
				frc_nx[i] = (m > POS_LIM) ? OUT_MAX : W'(m);
			end
			if (fixed_s9 || zero_s9) frc_nx[i] = '0;
		end
	end

	sdf_pkg::force_t res_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10.force_x     <= frc_nx[0];
			res_s10.force_y     <= frc_nx[1];
			res_s10.force_z     <= frc_nx[2];
			res_s10.skipped     <= fixed_s9;
			res_s10.zero_length <= !fixed_s9 && zero_s9;
		end
	end

	assign result_valid = vld_s10;
	assign result       = res_s10;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`SDF_ASSERT_NOW(a_flags_excl, result_valid, !(result.skipped && result.zero_length))
	`SDF_ASSERT_NOW(a_flag_zero, result_valid && (result.skipped || result.zero_length), result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
	`SDF_ASSERT_NOW(a_stall_only_out, !spring_ready, result_valid && !result_ready)
	`SDF_ASSERT_NEXT(a_hold_result, result_valid && !result_ready, result_valid && $stable(result))

endmodule

FILE: tb/spring_damper_force_test.sv
// Self-checking testbench for spring_damper_force: directed and random springs
// against a bit-exact force predictor in a small scoreboard class.
// Depends on sdf_pkg and the spring_damper_force RTL.
module spring_damper_force_test;
	import sdf_pkg::*;

	localparam int FRAC       = 16;
	localparam int LATENCY    = DATA_W + FRAC + 12;
	localparam int DOG_LIMIT  = 20000;
	localparam int MAX_REPORT = 10;

	// Expected forces, oldest first, plus the predictor's copy of the registers.
	class force_scoreboard;
		force_t          expected_q[$];
		logic [CFG_W-1:0] stiffness = STIFFNESS_RST;
		logic [CFG_W-1:0] damping   = DAMPING_RST;
		int              mismatches = 0;

		function longint unsigned mag(longint v);
			return (v < 0) ? longint'(-v) : v;
		endfunction

		// Q product truncated toward zero, magnitude clamped to 2^CAP_LOG2.
		function longint qmul(longint a, longint b);
			logic [127:0] p;
			longint m;
			p = 128'(mag(a)) * 128'(mag(b));
			p = p >> FRAC;
			if (p > (128'(1) << CAP_LOG2))
				m = longint'(64'(1) << CAP_LOG2);
			else
				m = longint'(p[63:0]);
			return ((a < 0) != (b < 0)) ? -m : m;
		endfunction

		function logic signed [DATA_W-1:0] saturate(longint v);
			longint hi;
			hi = (longint'(1) <<< (DATA_W - 1)) - 1;
			if (v > hi) v = hi;
			if (v < -hi - 1) v = -hi - 1;
			return v[DATA_W-1:0];
		endfunction

		function force_t spring_force(spring_t s);
			force_t f;
			longint d[3], v[3], e[3];
			logic [127:0] sum, m, t, q, root;
			longint vr, fsd, len;
			f = '0;
			if (s.both_fixed) begin
				f.skipped = 1'b1;
				return f;
			end
			d[0] = longint'(s.b_pos_x) - longint'(s.a_pos_x);
			d[1] = longint'(s.b_pos_y) - longint'(s.a_pos_y);
			d[2] = longint'(s.b_pos_z) - longint'(s.a_pos_z);
			v[0] = longint'(s.rel_vel_x);
			v[1] = longint'(s.rel_vel_y);
			v[2] = longint'(s.rel_vel_z);
			sum = '0;
			for (int i = 0; i < 3; i++) begin
				m = 128'(mag(d[i]));
				sum = sum + m * m;
			end
			if (sum == 0) begin
				f.zero_length = 1'b1;
				return f;
			end
			root = '0;
			for (int b = 50; b >= 0; b--) begin
				t = root | (128'(1) << b);
				if (t * t <= sum) root = t;
			end
			len = longint'(root[63:0]);
			vr = 0;
			for (int i = 0; i < 3; i++) begin
				q = (128'(mag(d[i])) << FRAC) / root;
				e[i] = (d[i] < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
				vr += qmul(v[i], e[i]);
			end
			fsd = qmul(longint'({32'b0, stiffness}), len - longint'({33'b0, s.rest_len}))
				- qmul(longint'({32'b0, damping}), vr);
			f.force_x = saturate(qmul(fsd, e[0]));
			f.force_y = saturate(qmul(fsd, e[1]));
			f.force_z = saturate(qmul(fsd, e[2]));
			return f;
		endfunction

		function void note_spring(spring_t s);
			expected_q.push_back(spring_force(s));
		endfunction

		function void check_force(force_t got);
			force_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display("unexpected result %h", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
					got.force_z !== want.force_z || got.skipped !== want.skipped ||
					got.zero_length !== want.zero_length) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display({"force mismatch: expected %0d %0d %0d s%b z%b, ",
						"got %0d %0d %0d s%b z%b"},
						want.force_x, want.force_y, want.force_z, want.skipped,
						want.zero_length, got.force_x, got.force_y, got.force_z,
						got.skipped, got.zero_length);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 spring_valid = 1'b0;
	logic                 spring_ready;
	spring_t              spring = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	force_t               result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_STIFFNESS;
	logic [CFG_W-1:0]     cfg_data = '0;

	force_scoreboard sb = new();
	bit quiet = 1'b0;   // no idling on either side
	int dog = 0;

	spring_damper_force #(.FRAC_BITS(FRAC)) u_top (
		.clk, .arst_n, .spring_valid, .spring_ready, .spring,
		.result_valid, .result_ready, .result, .cfg_we, .cfg_idx, .cfg_data
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall in random bursts, check every accepted result.
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready)
			sb.check_force(result);
	end

	// Watchdog: end the run after too many cycles without any accepted
	// request or result.
	always @(posedge clk) begin
		if ((spring_valid && spring_ready) || (result_valid && result_ready))
			dog = 0;
		else
			dog++;
		if (dog >= DOG_LIMIT) begin
			$display("FAIL spring_damper_force");
			$finish;
		end
	end

	// Hold a request until accepted; an optional gap drops valid first.
	task automatic send_spring(spring_t s);
		int gap;
		bit taken;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 19);
			spring_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		spring_valid = 1'b1;
		spring = s;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = spring_valid && spring_ready;
		end
		sb.note_spring(s);
	endtask

	// Wait for every expected result, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		spring_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_STIFFNESS) sb.stiffness = data;
		else sb.damping = data;
	endtask

	function automatic logic [DATA_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return DATA_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
			2: return DATA_W'(int'($urandom_range(0, 1 << 12)) - (1 << 11));
			default: return DATA_W'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
		endcase
	endfunction

	function automatic spring_t random_spring();
		spring_t s;
		s.a_pos_x = pick_coord();
		s.a_pos_y = pick_coord();
		s.a_pos_z = pick_coord();
		s.b_pos_x = pick_coord();
		s.b_pos_y = pick_coord();
		s.b_pos_z = pick_coord();
		s.rel_vel_x = pick_coord();
		s.rel_vel_y = pick_coord();
		s.rel_vel_z = pick_coord();
		s.rest_len = ($urandom_range(0, 1)) ? REST_W'($urandom())
			: REST_W'($urandom_range(0, 1 << 22));
		s.both_fixed = ($urandom_range(0, 19) == 0);
		// coincident particles now and then
		if ($urandom_range(0, 19) == 0) begin
			s.b_pos_x = s.a_pos_x;
			s.b_pos_y = s.a_pos_y;
			s.b_pos_z = s.a_pos_z;
		end
		return s;
	endfunction

	task automatic run_directed();
		spring_t s;
		logic signed [DATA_W-1:0] lo, hi;
		lo = {1'b1, {(DATA_W-1){1'b0}}};
		hi = {1'b0, {(DATA_W-1){1'b1}}};
		// extreme separation along each sign
		s = '{lo, lo, lo, hi, hi, hi, hi, hi, hi, '1, 1'b0};
		send_spring(s);
		s = '{hi, hi, hi, lo, lo, lo, lo, lo, lo, '0, 1'b0};
		send_spring(s);
		s = '{lo, hi, 0, hi, lo, 0, lo, hi, lo, '0, 1'b0};
		send_spring(s);
		// coincident particles, and pinned particles over both cases
		s = '{5, 6, 7, 5, 6, 7, hi, lo, 1, REST_W'(100), 1'b0};
		send_spring(s);
		s = '{5, 6, 7, 5, 6, 7, 0, 0, 0, '0, 1'b1};
		send_spring(s);
		s = '{0, 0, 0, 65536, 0, 0, 0, 0, 0, '0, 1'b1};
		send_spring(s);
		// single-axis and off-axis springs, stretched and compressed
		s = '{0, 0, 0, 65536, 0, 0, 0, 0, 0, REST_W'(32768), 1'b0};
		send_spring(s);
		s = '{0, 0, 0, 0, -65536, 0, 0, 65536, 0, REST_W'(131072), 1'b0};
		send_spring(s);
		s = '{0, 0, 0, 0, 0, 1, 0, 0, lo, '0, 1'b0};
		send_spring(s);
		s = '{0, 0, 0, 1, 1, 1, hi, hi, hi, '1, 1'b0};
		send_spring(s);
		s = '{lo, 0, 0, hi, 0, 0, 0, 0, 0, '1, 1'b0};
		send_spring(s);
		s = '{0, 0, 0, 196608, 262144, 0, -65536, 65536, 0, REST_W'(327680), 1'b0};
		send_spring(s);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			send_spring(random_spring());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random(300);
		drain();

		// zero coefficients
		write_reg(REG_STIFFNESS, '0);
		write_reg(REG_DAMPING, '0);
		run_directed();
		run_random(250);
		drain();

		// largest coefficients drive the forces into saturation
		write_reg(REG_STIFFNESS, '1);
		write_reg(REG_DAMPING, '1);
		run_directed();
		run_random(250);
		drain();

		write_reg(REG_STIFFNESS, 32'd262144);
		write_reg(REG_DAMPING, 32'd4096);
		run_random(300);
		drain();

		write_reg(REG_STIFFNESS, $urandom());
		write_reg(REG_DAMPING, $urandom());
		run_random(300);
		drain();

		write_reg(REG_STIFFNESS, $urandom_range(0, 1 << 20));
		write_reg(REG_DAMPING, $urandom_range(0, 1 << 20));
		run_random(250);
		drain();

		// last stretch at full rate on both sides
		write_reg(REG_STIFFNESS, STIFFNESS_RST);
		write_reg(REG_DAMPING, DAMPING_RST);
		quiet = 1'b1;
		run_random(250);
		drain();

		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("PASS spring_damper_force");
		end else begin
			$display("FAIL spring_damper_force");
		end
		$finish;
	end

endmodule
